### rtl/pcn_pkg.sv
`timescale 1ns / 1ps

package pcn_pkg;

    // Coordinates are signed Q16.16.
    localparam int COORD_W = 32;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Command codes
    localparam logic [3:0] FUNC_MOVE     = 4'd0;
    localparam logic [3:0] FUNC_LINE     = 4'd1;
    localparam logic [3:0] FUNC_QUAD     = 4'd2;
    localparam logic [3:0] FUNC_CUBIC    = 4'd3;
    localparam logic [3:0] FUNC_SQUAD    = 4'd4;
    localparam logic [3:0] FUNC_SCUBIC   = 4'd5;
    localparam logic [3:0] FUNC_HORIZ    = 4'd6;
    localparam logic [3:0] FUNC_VERT     = 4'd7;
    localparam logic [3:0] FUNC_CLOSE    = 4'd8;
    localparam logic [3:0] FUNC_CLEAR    = 4'd9;

    // Segment kinds
    localparam logic [2:0] KIND_MOVE  = 3'd0;
    localparam logic [2:0] KIND_LINE  = 3'd1;
    localparam logic [2:0] KIND_QUAD  = 3'd2;
    localparam logic [2:0] KIND_CUBIC = 3'd3;
    localparam logic [2:0] KIND_CLOSE = 3'd4;
    localparam logic [2:0] KIND_NONE  = 3'd7;

    typedef struct packed {
        logic [3:0] func;
        logic       rel;
        coord_t     pt1_x;
        coord_t     pt1_y;
        coord_t     pt2_x;
        coord_t     pt2_y;
        coord_t     pt3_x;
        coord_t     pt3_y;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        coord_t     out1_x;
        coord_t     out1_y;
        coord_t     out2_x;
        coord_t     out2_y;
        coord_t     out3_x;
        coord_t     out3_y;
    } seg_t;

    function automatic coord_t sat_add(coord_t a, coord_t b);
        logic signed [COORD_W:0] s;
        coord_t r;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            r = s[COORD_W] ? COORD_MIN : COORD_MAX;
        end else begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

    // c + (c - p) with saturation; saturating the exact 2c - p gives the same
    // answer as saturating each step.
    function automatic coord_t reflect(coord_t c, coord_t p);
        logic signed [COORD_W+1:0] s;
        coord_t r;
        s = {c[COORD_W-1], c, 1'b0} - {{2{p[COORD_W-1]}}, p};
        if (s[COORD_W+1:COORD_W-1] != 3'b000 && s[COORD_W+1:COORD_W-1] != 3'b111) begin
            r = s[COORD_W+1] ? COORD_MIN : COORD_MAX;
        end else begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/pcn_in_stage.sv
`timescale 1ns / 1ps

module pcn_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  pcn_pkg::cmd_t in_cmd,
    output logic          cmd_valid,
    input  logic          cmd_take,
    output pcn_pkg::cmd_t cmd
);
    import pcn_pkg::*;

    logic valid_reg;
    cmd_t cmd_reg;

    assign in_ready  = !valid_reg || cmd_take;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (cmd_take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            cmd_reg <= in_cmd;
        end
    end

endmodule

### rtl/pcn_engine.sv
`timescale 1ns / 1ps

module pcn_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  pcn_pkg::cmd_t cmd,
    output logic          emit,
    output pcn_pkg::seg_t seg
);
    import pcn_pkg::*;

    coord_t     last_x_reg, last_y_reg, last_x_next, last_y_next;
    coord_t     prev_x_reg, prev_y_reg, prev_x_next, prev_y_next;
    coord_t     start_x_reg, start_y_reg, start_x_next, start_y_next;
    logic [2:0] kind_reg, kind_next;
    logic       has_pts_reg, has_pts_next;

    coord_t cur_x, cur_y, off_x, off_y;
    coord_t a1_x, a1_y, a2_x, a2_y, a3_x, a3_y;
    coord_t refl_x, refl_y;

    always_comb begin
        // current point: origin on an empty path, subpath start after a close
        if (!has_pts_reg) begin
            cur_x = '0;
            cur_y = '0;
        end else if (kind_reg == KIND_CLOSE) begin
            cur_x = start_x_reg;
            cur_y = start_y_reg;
        end else begin
            cur_x = last_x_reg;
            cur_y = last_y_reg;
        end
        off_x  = cmd.rel ? cur_x : '0;
        off_y  = cmd.rel ? cur_y : '0;
        a1_x   = sat_add(cmd.pt1_x, off_x);
        a1_y   = sat_add(cmd.pt1_y, off_y);
        a2_x   = sat_add(cmd.pt2_x, off_x);
        a2_y   = sat_add(cmd.pt2_y, off_y);
        a3_x   = sat_add(cmd.pt3_x, off_x);
        a3_y   = sat_add(cmd.pt3_y, off_y);
        refl_x = reflect(last_x_reg, prev_x_reg);
        refl_y = reflect(last_y_reg, prev_y_reg);

        seg          = '0;
        emit         = 1'b0;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        kind_next    = kind_reg;
        has_pts_next = has_pts_reg;

        unique case (cmd.func) inside
            FUNC_MOVE, FUNC_LINE, FUNC_HORIZ, FUNC_VERT: begin
                emit       = 1'b1;
                seg.kind   = (cmd.func == FUNC_MOVE) ? KIND_MOVE : KIND_LINE;
                seg.out1_x = (cmd.func == FUNC_VERT) ? cur_x : a1_x;
                seg.out1_y = (cmd.func == FUNC_HORIZ) ? cur_y : a1_y;
            end
            FUNC_QUAD, FUNC_SQUAD: begin
                emit     = 1'b1;
                seg.kind = KIND_QUAD;
                if (cmd.func == FUNC_QUAD) begin
                    seg.out1_x = a1_x;
                    seg.out1_y = a1_y;
                end else if (kind_reg == KIND_QUAD) begin
                    seg.out1_x = refl_x;
                    seg.out1_y = refl_y;
                end else begin
                    seg.out1_x = cur_x;
                    seg.out1_y = cur_y;
                end
                seg.out2_x = a2_x;
                seg.out2_y = a2_y;
            end
            FUNC_CUBIC, FUNC_SCUBIC: begin
                emit     = 1'b1;
                seg.kind = KIND_CUBIC;
                if (cmd.func == FUNC_CUBIC) begin
                    seg.out1_x = a1_x;
                    seg.out1_y = a1_y;
                end else if (kind_reg == KIND_CUBIC) begin
                    seg.out1_x = refl_x;
                    seg.out1_y = refl_y;
                end else begin
                    seg.out1_x = cur_x;
                    seg.out1_y = cur_y;
                end
                seg.out2_x = a2_x;
                seg.out2_y = a2_y;
                seg.out3_x = a3_x;
                seg.out3_y = a3_y;
            end
            FUNC_CLOSE: begin
                // nothing on an empty path or right after another close
                if (kind_reg != KIND_NONE && kind_reg != KIND_CLOSE) begin
                    emit      = 1'b1;
                    seg.kind  = KIND_CLOSE;
                    kind_next = KIND_CLOSE;
                end
            end
            FUNC_CLEAR: begin
                last_x_next  = '0;
                last_y_next  = '0;
                prev_x_next  = '0;
                prev_y_next  = '0;
                start_x_next = '0;
                start_y_next = '0;
                kind_next    = KIND_NONE;
                has_pts_next = 1'b0;
            end
            default: begin
            end
        endcase

        // point history: curve's last two points, or old and new end point
        if (emit && seg.kind != KIND_CLOSE) begin
            kind_next    = seg.kind;
            has_pts_next = 1'b1;
            case (seg.kind)
                KIND_QUAD: begin
                    prev_x_next = seg.out1_x;
                    prev_y_next = seg.out1_y;
                    last_x_next = seg.out2_x;
                    last_y_next = seg.out2_y;
                end
                KIND_CUBIC: begin
                    prev_x_next = seg.out2_x;
                    prev_y_next = seg.out2_y;
                    last_x_next = seg.out3_x;
                    last_y_next = seg.out3_y;
                end
                default: begin
                    prev_x_next = last_x_reg;
                    prev_y_next = last_y_reg;
                    last_x_next = seg.out1_x;
                    last_y_next = seg.out1_y;
                end
            endcase
            if (seg.kind == KIND_MOVE) begin
                start_x_next = seg.out1_x;
                start_y_next = seg.out1_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            kind_reg    <= KIND_NONE;
            has_pts_reg <= 1'b0;
        end else if (fire) begin
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            kind_reg    <= kind_next;
            has_pts_reg <= has_pts_next;
        end
    end

endmodule

### rtl/path_command_normalizer.sv
`timescale 1ns / 1ps

// Path command normalizer: turns move, line, quadratic, cubic, smooth,
// horizontal, vertical, close and clear commands into absolute segments in
// signed Q16.16, with saturating arithmetic. One command is accepted per
// clock unless a full, unread output register stalls the input; a command
// is held in the input register, then its segment goes to the output
// register. The path state (current point, previous control point, subpath
// start) is updated in the same cycle as the segment is computed, which is
// what allows back-to-back commands. Clear, a close on an empty path, a
// repeated close and unused command codes produce no output transaction.
module path_command_normalizer (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [3:0]             s_func,
    input  logic                   s_rel,
    input  pcn_pkg::coord_t        s_pt1_x,
    input  pcn_pkg::coord_t        s_pt1_y,
    input  pcn_pkg::coord_t        s_pt2_x,
    input  pcn_pkg::coord_t        s_pt2_y,
    input  pcn_pkg::coord_t        s_pt3_x,
    input  pcn_pkg::coord_t        s_pt3_y,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_seg_kind,
    output pcn_pkg::coord_t        m_out1_x,
    output pcn_pkg::coord_t        m_out1_y,
    output pcn_pkg::coord_t        m_out2_x,
    output pcn_pkg::coord_t        m_out2_y,
    output pcn_pkg::coord_t        m_out3_x,
    output pcn_pkg::coord_t        m_out3_y
);
    import pcn_pkg::*;

    cmd_t in_cmd, cmd;
    seg_t seg, seg_reg;
    logic cmd_valid, fire, emit, out_free;
    logic m_valid_reg;

    assign in_cmd = '{func: s_func, rel: s_rel,
                      pt1_x: s_pt1_x, pt1_y: s_pt1_y,
                      pt2_x: s_pt2_x, pt2_y: s_pt2_y,
                      pt3_x: s_pt3_x, pt3_y: s_pt3_y};

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = cmd_valid && out_free;

    pcn_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (fire),
        .cmd       (cmd)
    );

    pcn_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .cmd     (cmd),
        .emit    (emit),
        .seg     (seg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            seg_reg <= seg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_seg_kind = seg_reg.kind;
    assign m_out1_x   = seg_reg.out1_x;
    assign m_out1_y   = seg_reg.out1_y;
    assign m_out2_x   = seg_reg.out2_x;
    assign m_out2_y   = seg_reg.out2_y;
    assign m_out3_x   = seg_reg.out3_x;
    assign m_out3_y   = seg_reg.out3_y;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !fire)
        else $error("output register overwritten while a transaction is pending");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_seg_kind <= KIND_CLOSE))
        else $error("segment kind out of range");

    a_close_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_seg_kind == KIND_CLOSE) |->
        (m_out1_x == '0 && m_out1_y == '0 && m_out2_x == '0 &&
         m_out2_y == '0 && m_out3_x == '0 && m_out3_y == '0))
        else $error("close segment carries nonzero points");

    a_line_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_seg_kind == KIND_MOVE || m_seg_kind == KIND_LINE)) |->
        (m_out2_x == '0 && m_out2_y == '0 && m_out3_x == '0 && m_out3_y == '0))
        else $error("move or line segment carries unused points");

endmodule

### tb/tb_path_command_normalizer.sv
`timescale 1ns / 1ps

module tb_path_command_normalizer;

    import pcn_pkg::*;

    localparam int N_DRAW      = 900;   // drawing commands in the random part
    localparam int TAIL_ITEMS  = 120;   // no idling once this few are left
    localparam int HOLD_AT     = 300;   // long output stall starts here
    localparam int HOLD_LEN    = 80;
    localparam int IDLE_LIMIT  = 2000;  // cycles without any transaction
    localparam int MAX_REPORTS = 10;

    localparam logic [3:0] FUNC_UNUSED_LO = FUNC_CLEAR + 4'd1;
    localparam logic [3:0] FUNC_UNUSED_HI = 4'hF;

    logic    aclk;
    logic    aresetn;
    logic    s_valid = 1'b0;
    logic    s_ready;
    logic [3:0] s_func = '0;
    logic    s_rel = 1'b0;
    coord_t  s_pt1_x = '0;
    coord_t  s_pt1_y = '0;
    coord_t  s_pt2_x = '0;
    coord_t  s_pt2_y = '0;
    coord_t  s_pt3_x = '0;
    coord_t  s_pt3_y = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    logic [2:0] m_seg_kind;
    coord_t  m_out1_x;
    coord_t  m_out1_y;
    coord_t  m_out2_x;
    coord_t  m_out2_y;
    coord_t  m_out3_x;
    coord_t  m_out3_y;

    path_command_normalizer dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_rel      (s_rel),
        .s_pt1_x    (s_pt1_x),
        .s_pt1_y    (s_pt1_y),
        .s_pt2_x    (s_pt2_x),
        .s_pt2_y    (s_pt2_y),
        .s_pt3_x    (s_pt3_x),
        .s_pt3_y    (s_pt3_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_seg_kind (m_seg_kind),
        .m_out1_x   (m_out1_x),
        .m_out1_y   (m_out1_y),
        .m_out2_x   (m_out2_x),
        .m_out2_y   (m_out2_y),
        .m_out3_x   (m_out3_x),
        .m_out3_y   (m_out3_y)
    );

    cmd_t cmd_pend_q[$];
    seg_t seg_expect_q[$];

    // path tracker state
    coord_t     pth_last_x, pth_last_y;
    coord_t     pth_prev_x, pth_prev_y;
    coord_t     pth_start_x, pth_start_y;
    logic [2:0] pth_kind;
    bit         pth_has_pts;

    int n_acc = 0;
    int n_silent = 0;
    int n_seg = 0;
    int n_err = 0;
    int idle_cyc = 0;
    int snd_gap = 0;
    int rcv_gap = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    bit tail_phase = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ---------------- path tracker ----------------

    function automatic coord_t clamp_coord(longint v);
        if (v > longint'(COORD_MAX)) return COORD_MAX;
        if (v < longint'(COORD_MIN)) return COORD_MIN;
        return coord_t'(v);
    endfunction

    function automatic coord_t add_sat(coord_t a, coord_t b);
        return clamp_coord(longint'(a) + longint'(b));
    endfunction

    // c + (c - p), each step clamped
    function automatic coord_t mirror_pt(coord_t c, coord_t p);
        return clamp_coord(longint'(c) + longint'(clamp_coord(longint'(c) - longint'(p))));
    endfunction

    function automatic void path_clear();
        pth_last_x = '0;
        pth_last_y = '0;
        pth_prev_x = '0;
        pth_prev_y = '0;
        pth_start_x = '0;
        pth_start_y = '0;
        pth_kind = KIND_NONE;
        pth_has_pts = 1'b0;
    endfunction

    // Returns 1 when the command yields a segment.
    function automatic bit normalize_cmd(input cmd_t c, output seg_t s);
        coord_t     cx, cy, ox, oy;
        coord_t     r[6];
        logic [2:0] k;
        int         n;
        s = '0;
        foreach (r[i]) r[i] = '0;
        n = 0;
        k = KIND_NONE;
        if (!pth_has_pts) begin
            cx = '0;
            cy = '0;
        end else if (pth_kind == KIND_CLOSE) begin
            cx = pth_start_x;
            cy = pth_start_y;
        end else begin
            cx = pth_last_x;
            cy = pth_last_y;
        end
        ox = c.rel ? cx : coord_t'(0);
        oy = c.rel ? cy : coord_t'(0);
        case (c.func)
            FUNC_MOVE, FUNC_LINE: begin
                r[0] = add_sat(c.pt1_x, ox);
                r[1] = add_sat(c.pt1_y, oy);
                n = 1;
                k = (c.func == FUNC_MOVE) ? KIND_MOVE : KIND_LINE;
            end
            FUNC_QUAD, FUNC_SQUAD: begin
                if (c.func == FUNC_QUAD) begin
                    r[0] = add_sat(c.pt1_x, ox);
                    r[1] = add_sat(c.pt1_y, oy);
                end else if (pth_kind == KIND_QUAD) begin
                    r[0] = mirror_pt(pth_last_x, pth_prev_x);
                    r[1] = mirror_pt(pth_last_y, pth_prev_y);
                end else begin
                    r[0] = cx;
                    r[1] = cy;
                end
                r[2] = add_sat(c.pt2_x, ox);
                r[3] = add_sat(c.pt2_y, oy);
                n = 2;
                k = KIND_QUAD;
            end
            FUNC_CUBIC, FUNC_SCUBIC: begin
                if (c.func == FUNC_CUBIC) begin
                    r[0] = add_sat(c.pt1_x, ox);
                    r[1] = add_sat(c.pt1_y, oy);
                end else if (pth_kind == KIND_CUBIC) begin
                    r[0] = mirror_pt(pth_last_x, pth_prev_x);
                    r[1] = mirror_pt(pth_last_y, pth_prev_y);
                end else begin
                    r[0] = cx;
                    r[1] = cy;
                end
                r[2] = add_sat(c.pt2_x, ox);
                r[3] = add_sat(c.pt2_y, oy);
                r[4] = add_sat(c.pt3_x, ox);
                r[5] = add_sat(c.pt3_y, oy);
                n = 3;
                k = KIND_CUBIC;
            end
            FUNC_HORIZ: begin
                r[0] = add_sat(c.pt1_x, ox);
                r[1] = cy;
                n = 1;
                k = KIND_LINE;
            end
            FUNC_VERT: begin
                r[0] = cx;
                r[1] = add_sat(c.pt1_y, oy);
                n = 1;
                k = KIND_LINE;
            end
            FUNC_CLOSE: begin
                if (pth_kind == KIND_NONE || pth_kind == KIND_CLOSE) return 1'b0;
                pth_kind = KIND_CLOSE;
                s.kind = KIND_CLOSE;
                return 1'b1;
            end
            FUNC_CLEAR: begin
                path_clear();
                return 1'b0;
            end
            default: return 1'b0;
        endcase
        for (int i = 0; i < n; i++) begin
            pth_prev_x = pth_last_x;
            pth_prev_y = pth_last_y;
            pth_last_x = r[2*i];
            pth_last_y = r[2*i+1];
            pth_has_pts = 1'b1;
        end
        if (k == KIND_MOVE) begin
            pth_start_x = r[0];
            pth_start_y = r[1];
        end
        pth_kind = k;
        s.kind = k;
        s.out1_x = r[0];
        s.out1_y = r[1];
        s.out2_x = r[2];
        s.out2_y = r[3];
        s.out3_x = r[4];
        s.out3_y = r[5];
        return 1'b1;
    endfunction

    // ---------------- stimulus ----------------

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return coord_t'(int'($urandom_range(0, 16)) - 8);
            4: return COORD_MAX - coord_t'($urandom_range(0, 255));
            5: return COORD_MIN + coord_t'($urandom_range(0, 255));
            6, 7: return coord_t'(int'($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic cmd_t mk_cmd(logic [3:0] f, logic r, coord_t ax, coord_t ay,
                                    coord_t bx, coord_t by, coord_t qx, coord_t qy);
        cmd_t c;
        c.func = f;
        c.rel = r;
        c.pt1_x = ax;
        c.pt1_y = ay;
        c.pt2_x = bx;
        c.pt2_y = by;
        c.pt3_x = qx;
        c.pt3_y = qy;
        return c;
    endfunction

    function automatic cmd_t rand_cmd(logic [3:0] f);
        return mk_cmd(f, 1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endfunction

    function automatic void add_cmd(cmd_t c);
        cmd_pend_q = {cmd_pend_q, c};
    endfunction

    function automatic logic [3:0] pick_draw(logic [3:0] prev);
        // favor smooth continuations so the reflection path gets exercised
        if ((prev == FUNC_QUAD || prev == FUNC_SQUAD) && $urandom_range(0, 1))
            return FUNC_SQUAD;
        if ((prev == FUNC_CUBIC || prev == FUNC_SCUBIC) && $urandom_range(0, 1))
            return FUNC_SCUBIC;
        case ($urandom_range(0, 6))
            0: return FUNC_LINE;
            1: return FUNC_QUAD;
            2: return FUNC_CUBIC;
            3: return FUNC_SQUAD;
            4: return FUNC_SCUBIC;
            5: return FUNC_HORIZ;
            default: return FUNC_VERT;
        endcase
    endfunction

    initial begin
        int         n_draw;
        int         len;
        logic [3:0] f, prev;
        path_clear();

        // directed
        add_cmd(mk_cmd(FUNC_CLOSE, 1'b0, 0, 0, 0, 0, 0, 0));  // empty path
        add_cmd(mk_cmd(FUNC_SQUAD, 1'b1, 5, 5, 32'sh1_0000, -32'sh1_0000, 0, 0));
        add_cmd(mk_cmd(FUNC_MOVE, 1'b0, COORD_MAX, COORD_MIN, 0, 0, 0, 0));
        add_cmd(mk_cmd(FUNC_LINE, 1'b1, 1, -1, 0, 0, 0, 0));  // saturates
        add_cmd(mk_cmd(FUNC_LINE, 1'b1, COORD_MIN, COORD_MAX, 0, 0, 0, 0));
        add_cmd(mk_cmd(FUNC_QUAD, 1'b0, 32'sh3_0000, -32'sh2_0000,
                       32'sh5_8000, 32'sh1_0000, -1, -1));
        add_cmd(mk_cmd(FUNC_SQUAD, 1'b1, COORD_MAX, COORD_MIN,
                       32'sh2_0000, 32'sh2_0000, 0, 0));
        add_cmd(mk_cmd(FUNC_SQUAD, 1'b0, 0, 0, -32'sh7_0000, 32'sh4_0000, 0, 0));
        add_cmd(mk_cmd(FUNC_SCUBIC, 1'b0, 0, 0, 32'sh1_0000, 32'sh1_0000,
                       32'sh2_0000, 32'sh3_0000));  // after quad: no reflection
        add_cmd(mk_cmd(FUNC_CUBIC, 1'b1, COORD_MAX, COORD_MIN,
                       COORD_MIN, COORD_MAX, 32'sh1_0000, -32'sh1_0000));
        add_cmd(mk_cmd(FUNC_SCUBIC, 1'b1, 0, 0, 32'sh8000, -32'sh8000,
                       32'sh1_0000, 32'sh1_0000));
        add_cmd(mk_cmd(FUNC_SQUAD, 1'b1, 0, 0, 3, 4, 0, 0));  // after cubic
        add_cmd(mk_cmd(FUNC_HORIZ, 1'b1, COORD_MAX, 7, 0, 0, 0, 0));
        add_cmd(mk_cmd(FUNC_VERT, 1'b1, 7, COORD_MIN, 0, 0, 0, 0));
        add_cmd(mk_cmd(FUNC_HORIZ, 1'b0, -32'sh10_0000, 9, 0, 0, 0, 0));
        add_cmd(mk_cmd(FUNC_VERT, 1'b0, 9, 32'sh10_0000, 0, 0, 0, 0));
        add_cmd(mk_cmd(FUNC_CLOSE, 1'b1, 1, 2, 3, 4, 5, 6));
        add_cmd(mk_cmd(FUNC_CLOSE, 1'b0, 0, 0, 0, 0, 0, 0));  // repeated close
        add_cmd(mk_cmd(FUNC_LINE, 1'b1, -32'sh1_0000, 1, 0, 0, 0, 0));
        add_cmd(mk_cmd(FUNC_UNUSED_LO, 1'b1, 1, 1, 1, 1, 1, 1));
        add_cmd(mk_cmd(FUNC_UNUSED_HI, 1'b0, -1, -1, -1, -1, -1, -1));
        add_cmd(mk_cmd(FUNC_CLEAR, 1'b1, 0, 0, 0, 0, 0, 0));
        add_cmd(mk_cmd(FUNC_MOVE, 1'b1, 0, 0, 0, 0, 0, 0));
        add_cmd(mk_cmd(FUNC_QUAD, 1'b0, COORD_MIN, COORD_MAX,
                       COORD_MAX, COORD_MIN, 0, 0));
        add_cmd(mk_cmd(FUNC_SQUAD, 1'b0, 0, 0, 0, 0, 0, 0));  // reflection clamps

        // random: mostly well-formed subpaths, some noise
        n_draw = 0;
        while (n_draw < N_DRAW) begin
            if ($urandom_range(0, 9) == 0) begin
                f = 4'($urandom_range(0, 15));
                add_cmd(rand_cmd(f));
                if (f <= FUNC_CLOSE) n_draw++;
            end else begin
                if ($urandom_range(0, 5) != 0) begin
                    add_cmd(rand_cmd(FUNC_MOVE));
                    n_draw++;
                end
                prev = FUNC_MOVE;
                len = $urandom_range(2, 8);
                repeat (len) begin
                    f = pick_draw(prev);
                    add_cmd(rand_cmd(f));
                    prev = f;
                    n_draw++;
                end
                if ($urandom_range(0, 1)) begin
                    add_cmd(rand_cmd(FUNC_CLOSE));
                    n_draw++;
                    if ($urandom_range(0, 3) == 0) begin
                        add_cmd(rand_cmd(FUNC_CLOSE));
                        n_draw++;
                    end
                end
                if ($urandom_range(0, 11) == 0) add_cmd(rand_cmd(FUNC_CLEAR));
            end
        end

        wait (aresetn === 1'b1);
        while (cmd_pend_q.size() != 0 || s_valid) @(posedge aclk);
        while (seg_expect_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d commands sent (%0d produced no segment), %0d segments compared",
                 n_acc, n_silent, n_seg);
        $display("covered saturation, smooth reflection, close/clear handling, full-output stall");
        if (n_err == 0) begin
            $display("tb_path_command_normalizer OK");
        end else begin
            $display("%0d mismatches", n_err);
            $display("tb_path_command_normalizer NOT OK");
        end
        $finish;
    end

    // ---------------- driver ----------------

    always @(posedge aclk) begin : drv
        seg_t seg;
        cmd_t acc, nx;
        bit   go;
        go = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                acc = mk_cmd(s_func, s_rel, s_pt1_x, s_pt1_y, s_pt2_x, s_pt2_y,
                             s_pt3_x, s_pt3_y);
                if (normalize_cmd(acc, seg)) seg_expect_q = {seg_expect_q, seg};
                else n_silent <= n_silent + 1;
                n_acc <= n_acc + 1;
            end
            if (cmd_pend_q.size() < TAIL_ITEMS) tail_phase <= 1'b1;

            if (s_valid && !s_ready) begin
                go = 1'b1;  // still waiting on the current transaction
            end else if (snd_gap > 0) begin
                snd_gap <= snd_gap - 1;
            end else if (cmd_pend_q.size() != 0) begin
                if (!tail_phase && hold_cnt == 0 && $urandom_range(0, 7) == 0) begin
                    snd_gap <= $urandom_range(0, 8);
                end else begin
                    nx = cmd_pend_q.pop_front();
                    s_func  <= nx.func;
                    s_rel   <= nx.rel;
                    s_pt1_x <= nx.pt1_x;
                    s_pt1_y <= nx.pt1_y;
                    s_pt2_x <= nx.pt2_x;
                    s_pt2_y <= nx.pt2_y;
                    s_pt3_x <= nx.pt3_x;
                    s_pt3_y <= nx.pt3_y;
                    go = 1'b1;
                end
            end
            s_valid <= go;
        end
    end

    // ---------------- receiver ----------------

    always @(posedge aclk) begin : rcv
        bit rdy;
        rdy = 1'b1;
        if (!aresetn) begin
            rdy = 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rdy = 1'b0;
        end else if (!hold_done && n_acc >= HOLD_AT) begin
            // long stall so the block backs up and drops s_ready
            hold_cnt <= HOLD_LEN - 1;
            hold_done <= 1'b1;
            rdy = 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap <= rcv_gap - 1;
            rdy = 1'b0;
        end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
            rcv_gap <= $urandom_range(0, 8);
            rdy = 1'b0;
        end
        m_ready <= rdy;
    end

    // ---------------- monitor ----------------

    task automatic log_miss(string msg);
        if (n_err < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
        n_err++;
    endtask

    task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
            log_miss($sformatf("segment %0d %s: expected %h, got %h", n_seg, name, want, got));
    endtask

    always @(posedge aclk) begin : mon
        seg_t want;
        if (aresetn && m_valid && m_ready) begin
            if (seg_expect_q.size() == 0) begin
                log_miss($sformatf("unexpected segment, kind %0d", m_seg_kind));
            end else begin
                want = seg_expect_q.pop_front();
                cmp_field("kind", 32'(want.kind), 32'(m_seg_kind));
                cmp_field("out1_x", want.out1_x, m_out1_x);
                cmp_field("out1_y", want.out1_y, m_out1_y);
                cmp_field("out2_x", want.out2_x, m_out2_x);
                cmp_field("out2_y", want.out2_y, m_out2_y);
                cmp_field("out3_x", want.out3_x, m_out3_x);
                cmp_field("out3_y", want.out3_y, m_out3_y);
            end
            n_seg <= n_seg + 1;
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge aclk) begin : wdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_path_command_normalizer NOT OK");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

endmodule
